// File: src/cce_pkg.sv
// Package for the chunk cache directory: shared types, codes and widths.
// Used by every module of the block but the checker; depends on nothing.
package cce_pkg;

  // Widths are sized for the largest directory the block supports (64 entries).
  localparam int IDX_W  = 6;   // slot index
  localparam int CNT_W  = 7;   // entry counts up to 64
  localparam int SUM_W  = 38;  // byte sum over 64 entries of 32 bits
  localparam int CHK_W  = 16;  // chunk index
  localparam int LAY_W  = 3;   // layer mask
  localparam int SIZE_W = 32;  // entry size
  localparam int ALW_W  = 4;   // window allowance, limit plus loan
  localparam int SCR_W  = CHK_W + 1;
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 64;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_KILL,
    OP_WRITE,
    OP_EVICT
  } cell_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WIN,
    S_KILL,
    S_LAUNCH,
    S_WAIT,
    S_EVAL,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_LOOKUP,
    PH_INSERT,
    PH_CEIL
  } phase_t;

  typedef enum logic [1:0] {
    REG_BEHIND,
    REG_AHEAD,
    REG_CEILING,
    REG_COUNT
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0]  behind;
    logic [2:0]  ahead;
    logic [39:0] ceiling;
    logic [16:0] count;
  } cce_cfg_t;

  // Broadcast command from the controller to every cell.
  typedef struct packed {
    cell_op_t           op;
    logic [CHK_W-1:0]   cur;
    logic [LAY_W-1:0]   mask;
    logic [SIZE_W-1:0]  bytes;
    logic [ALW_W-1:0]   allow_b;
    logic [ALW_W-1:0]   allow_a;
    logic [IDX_W-1:0]   slot;
  } cce_cmd_t;

  // Scan token that travels down the row of cells, one cell per cycle.
  typedef struct packed {
    logic               vld;
    logic               hit;
    logic [CNT_W-1:0]   held;
    logic [SUM_W-1:0]   bytes;
    logic [CNT_W-1:0]   killed;
    logic               free_found;
    logic [IDX_W-1:0]   free_idx;
    logic               vic_found;
    logic [IDX_W-1:0]   vic_idx;
    logic [SCR_W-1:0]   vic_score;
  } cce_tok_t;

endpackage

// File: src/cce_cell.sv
// One directory slot of the chunk cache with its stage of the scan token.
// Depends on cce_pkg.
module cce_cell
  import cce_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cce_cmd_t cmd,
  input  cce_tok_t tok_in,
  output cce_tok_t tok_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic              valid_r, valid_nxt;
  logic              killed_r, killed_nxt;
  logic [CHK_W-1:0]  chunk_r;
  logic [LAY_W-1:0]  layers_r;
  logic [SIZE_W-1:0] size_r;
  cce_tok_t          tok_r, tok_nxt;

  logic              same, behind, far, sel, drop;
  logic [CHK_W-1:0]  span;
  logic [SCR_W-1:0]  score;

  always_comb begin
    same   = valid_r && (chunk_r == cmd.cur);
    behind = chunk_r < cmd.cur;
    span   = behind ? (cmd.cur - chunk_r) : (chunk_r - cmd.cur);
    far    = behind ? (span > {{(CHK_W-ALW_W){1'b0}}, cmd.allow_b})
                    : (span > {{(CHK_W-ALW_W){1'b0}}, cmd.allow_a});
    score  = {span, behind};
    sel    = (cmd.slot == MY_IDX);
    drop   = same || (valid_r && far);
  end

  always_comb begin
    valid_nxt  = valid_r;
    killed_nxt = killed_r;
    case (cmd.op)
      OP_KILL: begin
        valid_nxt  = valid_r && !drop;
        killed_nxt = drop;
      end
      OP_WRITE: begin
        if (sel) valid_nxt = 1'b1;
      end
      OP_EVICT: begin
        if (sel) valid_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  // Fold this slot into the passing token.
  always_comb begin
    tok_nxt = tok_in;
    if (same && ((layers_r & cmd.mask) == cmd.mask)) tok_nxt.hit = 1'b1;
    if (valid_r) begin
      tok_nxt.held  = tok_in.held + CNT_W'(1);
      tok_nxt.bytes = tok_in.bytes + SUM_W'(size_r);
    end
    if (killed_r) tok_nxt.killed = tok_in.killed + CNT_W'(1);
    if (!tok_in.free_found && !valid_r) begin
      tok_nxt.free_found = 1'b1;
      tok_nxt.free_idx   = MY_IDX;
    end
    if (valid_r && !same && (!tok_in.vic_found || score > tok_in.vic_score)) begin
      tok_nxt.vic_found = 1'b1;
      tok_nxt.vic_idx   = MY_IDX;
      tok_nxt.vic_score = score;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      killed_r <= 1'b0;
      tok_r    <= '0;
    end else begin
      valid_r  <= valid_nxt;
      killed_r <= killed_nxt;
      tok_r    <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE && sel) begin
      chunk_r  <= cmd.cur;
      layers_r <= cmd.mask;
      size_r   <= cmd.bytes;
    end
  end

  assign tok_out = tok_r;

endmodule

// File: src/cce_cfg.sv
// Configuration register file of the chunk cache, behind an APB-style port.
// Depends on cce_pkg.
module cce_cfg
  import cce_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cce_cfg_t          cfg
);

  cce_cfg_t cfg_r, cfg_nxt;
  cfg_reg_t sel_reg;

  assign sel_reg = cfg_reg_t'(paddr[4:3]);
  assign pready  = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      unique case (sel_reg)
        REG_BEHIND:  cfg_nxt.behind  = pwdata[2:0];
        REG_AHEAD:   cfg_nxt.ahead   = pwdata[2:0];
        REG_CEILING: cfg_nxt.ceiling = pwdata[39:0];
        REG_COUNT:   cfg_nxt.count   = pwdata[16:0];
      endcase
    end
  end

  always_comb begin
    unique case (sel_reg)
      REG_BEHIND:  prdata = {61'd0, cfg_r.behind};
      REG_AHEAD:   prdata = {61'd0, cfg_r.ahead};
      REG_CEILING: prdata = {24'd0, cfg_r.ceiling};
      REG_COUNT:   prdata = {47'd0, cfg_r.count};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.behind  <= 3'd1;
      cfg_r.ahead   <= 3'd1;
      cfg_r.ceiling <= 40'd0;
      cfg_r.count   <= 17'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: src/chunk_cache_window_eviction.sv
// Top level of the chunk cache directory: controller, row of slot cells, registers.
// Depends on cce_pkg, cce_cell and cce_cfg.
//
//   channel  direction  handshake           beat carries
//   in_      input      in_valid/in_stall   mode, chunk_index, layer_mask, entry_bytes
//   out_     output     out_valid/out_stall hit, evicted_count, held_count, held_bytes
//   config   input      psel/penable/pwrite register write at paddr 8*i, 64-bit data
//
// With N = CACHE_ENTRIES, a lookup sends one scan token down the row of N cells; a store
// sets the window, drops entries, scans, writes the entry and scans again, plus one more
// scan for each entry evicted by the byte ceiling. The token walks one cell per cycle.
// Synchronous active-low reset empties the directory and loads the register defaults.
// in_stall is high from acceptance until the result is loaded into the output register;
// a result stalled downstream holds the block before it reloads that register.

module chunk_cache_window_eviction
  import cce_pkg::*;
#(
  parameter int CACHE_ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_mode,
  input  logic [15:0]       in_chunk_index,
  input  logic [2:0]        in_layer_mask,
  input  logic [31:0]       in_entry_bytes,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_hit,
  output logic [4:0]        out_evicted_count,
  output logic [4:0]        out_held_count,
  output logic [35:0]       out_held_bytes,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cce_cfg_t cfg;

  cce_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Controller state. The item being worked on is held in cur_r, mask_r and bytes_r;
  // the cells read those through the broadcast command for the whole operation.
  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [CHK_W-1:0]  cur_r, cur_nxt;
  logic [LAY_W-1:0]  mask_r, mask_nxt;
  logic [SIZE_W-1:0] bytes_r, bytes_nxt;
  logic [ALW_W-1:0]  allow_b_r, allow_b_nxt;
  logic [ALW_W-1:0]  allow_a_r, allow_a_nxt;
  logic [CNT_W-1:0]  evict_r, evict_nxt;
  cce_tok_t          res_r, res_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_hit_r, out_hit_nxt;
  logic [4:0]        out_evict_r, out_evict_nxt;
  logic [4:0]        out_held_r, out_held_nxt;
  logic [35:0]       out_bytes_r, out_bytes_nxt;

  cce_cmd_t          cmd;
  cce_tok_t          tok_head;
  cce_tok_t          tok_w [CACHE_ENTRIES+1];

  // Window allowance terms, worked out once per store in the window state.
  logic [16:0]       cur_plus1, avail_ahead;
  logic [2:0]        lend_behind, lend_ahead;

  always_comb begin
    cur_plus1   = {1'b0, cur_r} + 17'd1;
    avail_ahead = (cfg.count > cur_plus1) ? (cfg.count - cur_plus1) : 17'd0;
    lend_behind = ({14'd0, cfg.ahead} > avail_ahead) ? (cfg.ahead - avail_ahead[2:0]) : 3'd0;
    lend_ahead  = ({13'd0, cfg.behind} > cur_r) ? (cfg.behind - cur_r[2:0]) : 3'd0;
  end

  logic accept, out_free, over_ceiling;

  assign accept       = in_valid && !in_stall;
  assign out_free     = !out_valid_r || !out_stall;
  assign over_ceiling = (cfg.ceiling != 40'd0) && (res_r.held > CNT_W'(1)) &&
                        ({2'd0, res_r.bytes} > cfg.ceiling) && res_r.vic_found;

  // A fresh token enters the first cell only in the launch state.
  always_comb begin
    tok_head     = '0;
    tok_head.vld = (state_r == S_LAUNCH);
  end

  assign tok_w[0] = tok_head;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cur_nxt       = cur_r;
    mask_nxt      = mask_r;
    bytes_nxt     = bytes_r;
    allow_b_nxt   = allow_b_r;
    allow_a_nxt   = allow_a_r;
    evict_nxt     = evict_r;
    res_nxt       = res_r;
    out_hit_nxt   = out_hit_r;
    out_evict_nxt = out_evict_r;
    out_held_nxt  = out_held_r;
    out_bytes_nxt = out_bytes_r;
    out_valid_nxt = out_valid_r && out_stall;

    cmd.op      = OP_NONE;
    cmd.cur     = cur_r;
    cmd.mask    = mask_r;
    cmd.bytes   = bytes_r;
    cmd.allow_b = allow_b_r;
    cmd.allow_a = allow_a_r;
    cmd.slot    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cur_nxt   = in_chunk_index;
          mask_nxt  = in_layer_mask;
          bytes_nxt = in_entry_bytes;
          evict_nxt = '0;
          phase_nxt = in_mode ? PH_INSERT : PH_LOOKUP;
          state_nxt = in_mode ? S_WIN : S_LAUNCH;
        end
      end
      S_WIN: begin
        allow_b_nxt = {1'b0, cfg.behind} + {1'b0, lend_behind};
        allow_a_nxt = {1'b0, cfg.ahead} + {1'b0, lend_ahead};
        state_nxt   = S_KILL;
      end
      S_KILL: begin
        // Every cell drops a same-index entry or one outside the window at once.
        cmd.op    = OP_KILL;
        state_nxt = S_LAUNCH;
      end
      S_LAUNCH: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (tok_w[CACHE_ENTRIES].vld) begin
          res_nxt   = tok_w[CACHE_ENTRIES];
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        unique case (phase_r)
          PH_LOOKUP: begin
            state_nxt = S_DONE;
          end
          PH_INSERT: begin
            // Take the first free slot; a full directory gives up its farthest entry.
            cmd.op = OP_WRITE;
            if (res_r.free_found) begin
              cmd.slot  = res_r.free_idx;
              evict_nxt = res_r.killed;
            end else if (res_r.vic_found) begin
              cmd.slot  = res_r.vic_idx;
              evict_nxt = res_r.killed + CNT_W'(1);
            end else begin
              evict_nxt = res_r.killed;
            end
            phase_nxt = PH_CEIL;
            state_nxt = S_LAUNCH;
          end
          PH_CEIL: begin
            if (over_ceiling) begin
              cmd.op    = OP_EVICT;
              cmd.slot  = res_r.vic_idx;
              evict_nxt = evict_r + CNT_W'(1);
              state_nxt = S_LAUNCH;
            end else begin
              state_nxt = S_DONE;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = (phase_r == PH_LOOKUP) && res_r.hit;
          out_evict_nxt = 5'(evict_r);
          out_held_nxt  = 5'(res_r.held);
          out_bytes_nxt = 36'(res_r.bytes);
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  for (genvar k = 0; k < CACHE_ENTRIES; k++) begin : g_cell
    cce_cell #(.IDX(k)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .tok_in  (tok_w[k]),
      .tok_out (tok_w[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_LOOKUP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    mask_r      <= mask_nxt;
    bytes_r     <= bytes_nxt;
    allow_b_r   <= allow_b_nxt;
    allow_a_r   <= allow_a_nxt;
    evict_r     <= evict_nxt;
    res_r       <= res_nxt;
    out_hit_r   <= out_hit_nxt;
    out_evict_r <= out_evict_nxt;
    out_held_r  <= out_held_nxt;
    out_bytes_r <= out_bytes_nxt;
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_evicted_count = out_evict_r;
  assign out_held_count    = out_held_r;
  assign out_held_bytes    = out_bytes_r;

endmodule

// File: src/cce_checker.sv
// Port-level checks for the chunk cache directory, bound to the top level.
// Depends on chunk_cache_window_eviction for the bind target.
module cce_checker #(
  parameter int ENTRIES = 16
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_hit,
  input logic [4:0] out_evicted_count,
  input logic [4:0] out_held_count
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // The block works on one item at a time: an accepted beat stalls the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while an item is in work");

  // Only a lookup can hit, and a lookup never evicts.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_evicted_count == 5'd0)
    else $error("hit reported together with evictions");

  // A store that evicted always leaves at least the current chunk held.
  a_store_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted_count != 5'd0 |-> (ENTRIES >= 32) || out_held_count != 5'd0)
    else $error("store left the directory empty");

endmodule

bind chunk_cache_window_eviction cce_checker #(.ENTRIES(CACHE_ENTRIES)) u_cce_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_hit           (out_hit),
  .out_evicted_count (out_evicted_count),
  .out_held_count    (out_held_count)
);
